// File: rtl/core/lrs_pkg.sv
// Package for the link reconnect supervisor: phase codes, register indexes,
// state, configuration, tick and result structs, and the backoff step and
// reached functions. No dependencies.
package lrs_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [TIME_W-1:0] ATTEMPT_HOLDOFF_MS = 32'd1000;

    typedef enum logic [2:0] {
        PH_WARMUP          = 3'd0,
        PH_BEGIN           = 3'd1,
        PH_WAIT            = 3'd2,
        PH_LINK_BACKOFF    = 3'd3,
        PH_SESSION_TRY     = 3'd4,
        PH_SESSION_BACKOFF = 3'd5,
        PH_OK              = 3'd6
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WARMUP          = 3'd0,
        REG_LINK_TIMEOUT    = 3'd1,
        REG_LINK_BO_BASE    = 3'd2,
        REG_LINK_BO_MAX     = 3'd3,
        REG_SESSION_TIMEOUT = 3'd4,
        REG_RETRY_INTERVAL  = 3'd5,
        REG_SESSION_BO_BASE = 3'd6,
        REG_SESSION_BO_MAX  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] warmup_ms;
        logic [TIME_W-1:0] link_timeout_ms;
        logic [TIME_W-1:0] link_backoff_base_ms;
        logic [TIME_W-1:0] link_backoff_max_ms;
        logic [TIME_W-1:0] session_total_timeout_ms;
        logic [TIME_W-1:0] retry_interval_ms;
        logic [TIME_W-1:0] session_backoff_base_ms;
        logic [TIME_W-1:0] session_backoff_max_ms;
    } cfg_t;

    typedef struct packed {
        phase_t            cur_phase;
        logic [TIME_W-1:0] phase_start;
        logic [TIME_W-1:0] link_backoff;
        logic [TIME_W-1:0] link_backoff_until;
        logic [TIME_W-1:0] session_backoff;
        logic [TIME_W-1:0] session_backoff_until;
        logic [TIME_W-1:0] session_start;
        logic [TIME_W-1:0] last_try;
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              session_up;
        logic              connect_ok;
        logic              subscribe_ok;
    } tick_t;

    typedef struct packed {
        logic   show_error;
        logic   cmd_publish_online;
        logic   cmd_stop;
        logic   cmd_connect;
        logic   cmd_configure;
        logic   cmd_link_begin;
        phase_t phase;
    } result_t;

    // Zero starts at the base; otherwise double, capped at the maximum,
    // and an overflowing doubling also lands on the maximum.
    function automatic logic [TIME_W-1:0] step_backoff(
        input logic [TIME_W-1:0] cur,
        input logic [TIME_W-1:0] base,
        input logic [TIME_W-1:0] max_ms
    );
        logic [TIME_W-1:0] dbl;
        dbl = {cur[TIME_W-2:0], 1'b0};
        if (cur == '0) begin
            return base;
        end else if (cur[TIME_W-1]) begin
            return max_ms;
        end else if (dbl > max_ms) begin
            return max_ms;
        end else begin
            return dbl;
        end
    endfunction

    // True once now has reached until, taken as a signed 32-bit difference.
    function automatic logic reached(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] until_ms
    );
        logic [TIME_W-1:0] diff;
        diff = now - until_ms;
        return ~diff[TIME_W-1];
    endfunction

endpackage

// File: rtl/core/link_reconnect_supervisor.sv
// Top level of the link reconnect supervisor: tick input register, phase
// state, configuration registers and the result register. Depends on lrs_pkg
// and lrs_step.
//
//  Channel  Direction  Handshake               Payload
//  s_       in         s_tvalid / s_tready     s_tdata: one tick
//  m_       out        m_tvalid / m_tready     m_tdata: phase and commands
//  cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each tick beat is captured in the input register, evaluated combinationally
// and written to the result register, so a new beat is taken every cycle
// while the result side is not stalled.
// Reset puts the phase in warmup, clears all timestamps and loads the
// default register values. A stalled result holds the pipeline; once both
// the input and the result register are full, s_tready stays low until the
// result beat is taken.
module link_reconnect_supervisor #(
    parameter logic [lrs_pkg::TIME_W-1:0] ATTEMPT_HOLDOFF_MS = lrs_pkg::ATTEMPT_HOLDOFF_MS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0: now_ms[31:0], link_up, session_up, connect_ok,
    // subscribe_ok, zero fill to 40 bits.
    input  logic [lrs_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0: phase[2:0], cmd_link_begin, cmd_configure,
    // cmd_connect, cmd_stop, cmd_publish_online, show_error, zero fill to 16.
    output logic [lrs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lrs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lrs_pkg::TIME_W-1:0]        cfg_data
);

    logic             in_valid_reg;
    lrs_pkg::tick_t   in_tick_reg;
    logic             out_valid_reg;
    lrs_pkg::result_t out_res_reg;
    lrs_pkg::state_t  state_reg;
    lrs_pkg::state_t  state_next;
    lrs_pkg::result_t res_next;
    lrs_pkg::cfg_t    cfg_reg;
    logic             advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(lrs_pkg::M_TDATA_W - $bits(lrs_pkg::result_t)){1'b0}},
                        out_res_reg};

    lrs_step #(
        .ATTEMPT_HOLDOFF_MS (ATTEMPT_HOLDOFF_MS)
    ) u_step (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .tick    (in_tick_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{cur_phase: lrs_pkg::PH_WARMUP, default: '0};
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg.now_ms       <= s_tdata[31:0];
            in_tick_reg.link_up      <= s_tdata[32];
            in_tick_reg.session_up   <= s_tdata[33];
            in_tick_reg.connect_ok   <= s_tdata[34];
            in_tick_reg.subscribe_ok <= s_tdata[35];
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_ms                <= 32'd2000;
            cfg_reg.link_timeout_ms          <= 32'd15000;
            cfg_reg.link_backoff_base_ms     <= 32'd1000;
            cfg_reg.link_backoff_max_ms      <= 32'd60000;
            cfg_reg.session_total_timeout_ms <= 32'd30000;
            cfg_reg.retry_interval_ms        <= 32'd2000;
            cfg_reg.session_backoff_base_ms  <= 32'd1000;
            cfg_reg.session_backoff_max_ms   <= 32'd60000;
        end else if (cfg_valid && cfg_ready) begin
            case (lrs_pkg::cfg_index_t'(cfg_index))
                lrs_pkg::REG_WARMUP:          cfg_reg.warmup_ms <= cfg_data;
                lrs_pkg::REG_LINK_TIMEOUT:    cfg_reg.link_timeout_ms <= cfg_data;
                lrs_pkg::REG_LINK_BO_BASE:    cfg_reg.link_backoff_base_ms <= cfg_data;
                lrs_pkg::REG_LINK_BO_MAX:     cfg_reg.link_backoff_max_ms <= cfg_data;
                lrs_pkg::REG_SESSION_TIMEOUT: cfg_reg.session_total_timeout_ms <= cfg_data;
                lrs_pkg::REG_RETRY_INTERVAL:  cfg_reg.retry_interval_ms <= cfg_data;
                lrs_pkg::REG_SESSION_BO_BASE: cfg_reg.session_backoff_base_ms <= cfg_data;
                lrs_pkg::REG_SESSION_BO_MAX:  cfg_reg.session_backoff_max_ms <= cfg_data;
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/lrs_step.sv
// One tick of the supervisor phase machine: next state and the result beat.
// Depends on lrs_pkg.
module lrs_step #(
    parameter logic [lrs_pkg::TIME_W-1:0] ATTEMPT_HOLDOFF_MS = lrs_pkg::ATTEMPT_HOLDOFF_MS
) (
    input  lrs_pkg::cfg_t    cfg,
    input  lrs_pkg::state_t  st,
    input  lrs_pkg::tick_t   tick,
    output lrs_pkg::state_t  st_next,
    output lrs_pkg::result_t res
);

    logic [lrs_pkg::TIME_W-1:0] now;
    logic [lrs_pkg::TIME_W-1:0] warm_start;
    logic                       warm_done;
    logic                       wait_expired;
    logic                       session_expired;
    logic                       try_allowed;
    logic                       link_bo_done;
    logic                       session_bo_done;

    assign now        = tick.now_ms;
    assign warm_start = (st.phase_start == '0) ? now : st.phase_start;
    assign warm_done  = (now - warm_start) >= cfg.warmup_ms;
    assign wait_expired = (now - st.phase_start) >= cfg.link_timeout_ms;
    assign session_expired = (cfg.session_total_timeout_ms != '0) &&
                             ((now - st.session_start) >= cfg.session_total_timeout_ms);
    assign try_allowed = ((now - st.phase_start) >= ATTEMPT_HOLDOFF_MS) &&
                         ((st.last_try == '0) ||
                          ((now - st.last_try) >= cfg.retry_interval_ms));
    assign link_bo_done    = lrs_pkg::reached(now, st.link_backoff_until);
    assign session_bo_done = lrs_pkg::reached(now, st.session_backoff_until);

    always_comb begin
        logic [lrs_pkg::TIME_W-1:0] bo;
        bo  = '0;
        st_next = st;
        res = '0;

        if (st.cur_phase == lrs_pkg::PH_OK && !tick.link_up) begin
            res.cmd_stop = 1'b1;
            st_next.cur_phase   = lrs_pkg::PH_WARMUP;
            st_next.phase_start = now;
        end else if (st.cur_phase == lrs_pkg::PH_OK && !tick.session_up) begin
            st_next.session_start = now;
            st_next.last_try      = '0;
            st_next.cur_phase     = lrs_pkg::PH_SESSION_TRY;
            st_next.phase_start   = now;
        end else begin
            case (st.cur_phase)
                lrs_pkg::PH_WARMUP: begin
                    st_next.phase_start = warm_start;
                    if (warm_done) begin
                        st_next.cur_phase   = lrs_pkg::PH_BEGIN;
                        st_next.phase_start = now;
                    end
                end
                lrs_pkg::PH_BEGIN: begin
                    res.cmd_link_begin  = 1'b1;
                    st_next.cur_phase   = lrs_pkg::PH_WAIT;
                    st_next.phase_start = now;
                end
                lrs_pkg::PH_WAIT: begin
                    if (tick.link_up) begin
                        res.cmd_configure     = 1'b1;
                        st_next.link_backoff  = '0;
                        st_next.session_start = now;
                        st_next.last_try      = '0;
                        st_next.cur_phase     = lrs_pkg::PH_SESSION_TRY;
                        st_next.phase_start   = now;
                    end else if (wait_expired) begin
                        res.show_error = 1'b1;
                        bo = lrs_pkg::step_backoff(st.link_backoff,
                                                   cfg.link_backoff_base_ms,
                                                   cfg.link_backoff_max_ms);
                        st_next.link_backoff       = bo;
                        st_next.link_backoff_until = now + bo;
                        st_next.cur_phase          = lrs_pkg::PH_LINK_BACKOFF;
                        st_next.phase_start        = now;
                    end
                end
                lrs_pkg::PH_LINK_BACKOFF: begin
                    res.show_error = 1'b1;
                    if (link_bo_done) begin
                        st_next.cur_phase   = lrs_pkg::PH_WARMUP;
                        st_next.phase_start = now;
                    end
                end
                lrs_pkg::PH_SESSION_TRY: begin
                    if (session_expired) begin
                        res.show_error = 1'b1;
                        bo = lrs_pkg::step_backoff(st.session_backoff,
                                                   cfg.session_backoff_base_ms,
                                                   cfg.session_backoff_max_ms);
                        st_next.session_backoff       = bo;
                        st_next.session_backoff_until = now + bo;
                        st_next.cur_phase             = lrs_pkg::PH_SESSION_BACKOFF;
                        st_next.phase_start           = now;
                    end else if (try_allowed) begin
                        res.cmd_connect  = 1'b1;
                        st_next.last_try = now;
                        if (tick.connect_ok) begin
                            if (tick.subscribe_ok) begin
                                res.cmd_publish_online  = 1'b1;
                                st_next.session_backoff = '0;
                                st_next.cur_phase       = lrs_pkg::PH_OK;
                                st_next.phase_start     = now;
                            end else begin
                                res.cmd_stop = 1'b1;
                            end
                        end
                    end
                end
                lrs_pkg::PH_SESSION_BACKOFF: begin
                    res.show_error = 1'b1;
                    if (session_bo_done) begin
                        st_next.phase_start = now;
                        if (!tick.link_up) begin
                            st_next.cur_phase = lrs_pkg::PH_WARMUP;
                        end else begin
                            st_next.session_start = now;
                            st_next.cur_phase     = lrs_pkg::PH_SESSION_TRY;
                        end
                    end
                end
                default: begin
                    // Ok with both link and session up, or the unused code:
                    // nothing changes.
                    st_next = st;
                end
            endcase
        end
        res.phase = st_next.cur_phase;
    end

endmodule
